### sv/ttb_pkg.sv
// ttb_pkg: widths, formats and payload types for the tangent/binormal block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ttb_pkg;
  localparam int CW      = 16;                 // coordinate width
  localparam int RW      = 32;                 // result width
  localparam int POSF    = CW / 2;
  localparam int TEXF    = CW - 2;
  localparam int RESF    = RW / 2;
  localparam int QSHIFT  = RESF - POSF + TEXF;
  localparam int DW      = CW + 1;             // difference width
  localparam int PW      = 2 * DW + 1;         // product difference width, signed
  localparam int NW      = PW + QSHIFT;        // shifted numerator magnitude width
  localparam int QCW     = $clog2(NW + 1);
  localparam int MCW     = $clog2(DW + 1);
  localparam int OUT_BYTES = (6 * RW + 7) / 8;

  typedef struct packed {
    logic signed [RW-1:0] bz, by, bx, tz, ty, tx;
  } vec_t;

  typedef struct packed {
    logic       last_of_triangle;
    logic       degenerate;
    logic [1:0] corner;
  } res_flags_t;
endpackage
`default_nettype wire

### sv/ttb_mul.sv
// ttb_mul: serial shift-add signed multiplier, one multiplier bit per cycle
// depends on ttb_pkg
`timescale 1ns / 1ps
`default_nettype none
module ttb_mul import ttb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [DW-1:0] a,
  input  wire logic signed [DW-1:0] b,
  output logic                      done,
  output logic signed [2*DW-1:0]    prod
);
  logic [MCW-1:0]          cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic [DW-1:0]           mb_r, mb_nxt;
  logic signed [2*DW-1:0]  acc_r, acc_nxt, ma_r, ma_nxt;

  // shift-add over magnitude of b with sign applied to a
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    mb_nxt   = mb_r;
    acc_nxt  = acc_r;
    ma_nxt   = ma_r;
    done     = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      mb_nxt   = b[DW-1] ? DW'(-b) : DW'(b);
      ma_nxt   = b[DW-1] ? -(2*DW)'(a) : (2*DW)'(a);
    end else if (busy_r) begin
      if (mb_r[0]) acc_nxt = acc_r + ma_r;
      ma_nxt = ma_r <<< 1;
      mb_nxt = mb_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MCW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end
    end
  end
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
    ma_r  <= ma_nxt;
  end
endmodule
`default_nettype wire

### sv/ttb_div.sv
// ttb_div: restoring divider, one quotient bit per cycle, with saturation
// depends on ttb_pkg
`timescale 1ns / 1ps
`default_nettype none
module ttb_div import ttb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [PW-1:0] num,
  input  wire logic signed [PW-1:0] den,
  output logic                      done,
  output logic signed [RW-1:0]      quo
);
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt, neg_r, neg_nxt;
  logic           done_r, done_nxt;
  logic [NW-1:0]  n_r, n_nxt, q_r, q_nxt;
  logic [PW:0]    rem_r, rem_nxt, trial;
  logic [PW-1:0]  d_r, d_nxt;
  logic [NW-1:0]  lim;

  always_comb begin
    cnt_nxt = cnt_r; busy_nxt = busy_r; neg_nxt = neg_r;
    n_nxt = n_r; q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r;
    done_nxt = 1'b0;
    trial = {rem_r[PW-1:0], n_r[NW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = num[PW-1] ^ den[PW-1];
      n_nxt    = NW'(num[PW-1] ? PW'(-num) : PW'(num)) << QSHIFT;
      d_nxt    = den[PW-1] ? PW'(-den) : PW'(den);
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      // one restoring step
      n_nxt = n_r << 1;
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      // done is flagged once the last quotient bit is in q_r
      if (cnt_r == QCW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end
  assign done = done_r;

  // saturate and apply sign
  always_comb begin
    lim = neg_r ? (NW'(1) << (RW - 1)) : ((NW'(1) << (RW - 1)) - 1'b1);
    if (q_r > lim) quo = neg_r ? RW'(-lim) : RW'(lim);
    else           quo = neg_r ? RW'(-q_r) : RW'(q_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt; n_r <= n_nxt; q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
  end
endmodule
`default_nettype wire

### sv/triangle_tangent_binormal.sv
// Tangent/binormal per vertex. Vertices stream in; every third completes a
// triangle and yields three result words (corner 0,1,2). Arithmetic runs on a
// serial multiplier and a restoring divider (one bit per cycle). A first or second
// vertex is only stored; a third vertex occupies the block until its three results
// are sent, with 14 products and 6 divisions per corner, 18 divisions per triangle;
// a degenerate corner skips its numerator products and divisions.
// Results are Q16.16, saturated; a zero uv determinant gives zeros and degenerate.
// depends on ttb_pkg, ttb_mul, ttb_div
`timescale 1ns / 1ps
`default_nettype none
module triangle_tangent_binormal import ttb_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v
  input  wire logic [5*CW-1:0] in_tdata,
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tangent_x/y/z, binormal_x/y/z
  output logic [8*OUT_BYTES-1:0] out_tdata,
  // corner[1:0], degenerate
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);
  localparam logic [2:0] S_IN = 3'd0, S_MUL = 3'd1, S_MULW = 3'd2,
                         S_DIV = 3'd3, S_DIVW = 3'd4, S_OUT = 3'd5;

  logic [2:0] st_r, st_nxt;
  logic [1:0] phase_r, corner_r;
  logic [2:0] dstep_r;
  logic signed [CW-1:0] p_r [3][3];
  logic signed [CW-1:0] t_r [3][2];
  logic signed [PW-1:0] det_r, prod0_r;
  logic signed [DW-1:0] du1, dv1, du2, dv2, e1, e2, ma, mb;
  logic [1:0] ib, ic, ax;
  logic mstart, mdone, dstart, ddone, half_r;
  logic signed [2*DW-1:0] prod;
  logic signed [RW-1:0] quo;
  logic signed [PW-1:0] dnum;
  vec_t v_r;
  res_flags_t fl;
  logic accept, degen, dzero;

  assign ib = (corner_r == 2'd2) ? 2'd0 : corner_r + 2'd1;
  assign ic = (corner_r == 2'd0) ? 2'd2 : corner_r - 2'd1;
  assign ax = (dstep_r >= 3'd3) ? 2'(dstep_r - 3'd3) : dstep_r[1:0];
  assign du1 = DW'(t_r[ib][0]) - DW'(t_r[corner_r][0]);
  assign dv1 = DW'(t_r[ib][1]) - DW'(t_r[corner_r][1]);
  assign du2 = DW'(t_r[ic][0]) - DW'(t_r[corner_r][0]);
  assign dv2 = DW'(t_r[ic][1]) - DW'(t_r[corner_r][1]);
  assign e1  = DW'(p_r[ib][ax]) - DW'(p_r[corner_r][ax]);
  assign e2  = DW'(p_r[ic][ax]) - DW'(p_r[corner_r][ax]);
  assign degen = (det_r == '0);

  // operand selection: det needs du1*dv2, du2*dv1; numerators use two products each
  always_comb begin
    ma = du1; mb = dv2;
    if (dstep_r == 3'd7) begin
      ma = half_r ? du2 : du1; mb = half_r ? dv1 : dv2;
    end else if (dstep_r < 3'd3) begin
      ma = half_r ? e2 : e1; mb = half_r ? dv1 : dv2;
    end else begin
      ma = half_r ? e1 : e2; mb = half_r ? du2 : du1;
    end
  end
  assign dnum = prod0_r - PW'(prod);
  // determinant about to be stored is zero
  assign dzero = (dnum == '0);

  ttb_mul u_mul (.clk, .rst_n, .start(mstart), .a(ma), .b(mb), .done(mdone), .prod);
  ttb_div u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(det_r), .done(ddone), .quo);

  assign in_tready = (st_r == S_IN);
  assign accept = in_tvalid && in_tready;
  assign mstart = (st_r == S_MUL);

  // sequencer: det (dstep 7), then, unless det is zero, six numerators (dstep 0..5) each two products
  always_comb begin
    st_nxt = st_r; dstart = 1'b0;
    case (st_r)
      S_IN:   if (accept && phase_r == 2'd2) st_nxt = S_MUL;
      S_MUL:  st_nxt = S_MULW;
      S_MULW: if (mdone) begin
        if (!half_r) st_nxt = S_MUL;
        else if (dstep_r == 3'd7) st_nxt = dzero ? S_OUT : S_MUL;
        else begin st_nxt = S_DIV; end
      end
      S_DIV:  begin dstart = 1'b1; st_nxt = S_DIVW; end
      S_DIVW: if (ddone) st_nxt = (dstep_r == 3'd5) ? S_OUT : S_MUL;
      S_OUT:  if (out_tready) st_nxt = (corner_r == 2'd2) ? S_IN : S_MUL;
      default: st_nxt = S_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IN; phase_r <= '0; corner_r <= '0; dstep_r <= 3'd7; half_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (accept) begin
        if (phase_r == 2'd2) begin
          phase_r <= '0; corner_r <= '0; dstep_r <= 3'd7; half_r <= 1'b0;
        end else phase_r <= in_tlast ? 2'd0 : phase_r + 2'd1;
      end
      if (st_r == S_MULW && mdone) begin
        half_r <= ~half_r;
        if (half_r && dstep_r == 3'd7) dstep_r <= dzero ? 3'd7 : 3'd0;
      end
      if (st_r == S_DIVW && ddone && dstep_r != 3'd5) dstep_r <= dstep_r + 3'd1;
      if (st_r == S_OUT && out_tready) begin
        corner_r <= (corner_r == 2'd2) ? 2'd0 : corner_r + 2'd1;
        dstep_r <= 3'd7;
      end
    end
    // vertex store
    if (accept) begin
      p_r[phase_r][0] <= in_tdata[0*CW +: CW];
      p_r[phase_r][1] <= in_tdata[1*CW +: CW];
      p_r[phase_r][2] <= in_tdata[2*CW +: CW];
      t_r[phase_r][0] <= in_tdata[3*CW +: CW];
      t_r[phase_r][1] <= in_tdata[4*CW +: CW];
    end
    if (st_r == S_MULW && mdone && !half_r) prod0_r <= PW'(prod);
    if (st_r == S_MULW && mdone && half_r && dstep_r == 3'd7) begin
      det_r <= dnum;
      if (dzero) v_r <= '0;
    end
    if (st_r == S_DIVW && ddone) begin
      case (dstep_r)
        3'd0: v_r.tx <= quo;
        3'd1: v_r.ty <= quo;
        3'd2: v_r.tz <= quo;
        3'd3: v_r.bx <= quo;
        3'd4: v_r.by <= quo;
        default: v_r.bz <= quo;
      endcase
    end
  end

  assign fl.corner = corner_r;
  assign fl.degenerate = degen;
  assign fl.last_of_triangle = (corner_r == 2'd2);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata = {v_r.bz, v_r.by, v_r.bx, v_r.tz, v_r.ty, v_r.tx};
  assign out_tuser = {fl.degenerate, fl.corner};
  assign out_tlast = fl.last_of_triangle;

`ifndef NO_ASSERTIONS
  a_noin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken during output");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped");
  a_ph: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3) else $error("bad phase");
`endif
endmodule
`default_nettype wire
